// ----- rtl/fwip_pkg.sv -----
// shared types, width codes and the queue depth for the fixed width integer packer
package fwip_pkg;

    localparam logic [2:0] WCODE_1  = 3'd0;
    localparam logic [2:0] WCODE_2  = 3'd1;
    localparam logic [2:0] WCODE_4  = 3'd2;
    localparam logic [2:0] WCODE_8  = 3'd3;
    localparam logic [2:0] WCODE_16 = 3'd4;
    localparam logic [2:0] WCODE_32 = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [31:0] value;
        logic        first;
        logic [2:0]  count_low;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    // one queued job: up to four bytes, little-endian
    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  nbytes_m1;
        logic        last;
    } job_t;

    // queue status seen by the front (full) and the back (empty)
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ----- rtl/fwip_front.sv -----
// front part: accepts values, packs sub-byte widths and forms byte jobs
module fwip_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         width_code,
    input  logic               in_valid,
    output logic               in_ready,
    input  fwip_pkg::in_item_t in_data,
    input  logic               queue_full,
    output logic               push,
    output fwip_pkg::job_t     push_job
);

    logic [7:0] acc_reg, acc_next;
    logic [2:0] slot_reg, slot_next;
    logic       accept;
    logic       sub_byte;
    logic [2:0] slot_eff;
    logic [7:0] acc_base;
    logic [7:0] mask;
    logic [3:0] wbits;
    logic [5:0] pos;
    logic [2:0] shift;
    logic [2:0] endp;
    logic [7:0] acc_new;
    logic       emit;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign sub_byte = (width_code == fwip_pkg::WCODE_1) || (width_code == fwip_pkg::WCODE_2)
                   || (width_code == fwip_pkg::WCODE_4);

    always_comb
    begin
        case (width_code)
            fwip_pkg::WCODE_1:
            begin
                mask  = 8'h01;
                wbits = 4'd1;
            end
            fwip_pkg::WCODE_2:
            begin
                mask  = 8'h03;
                wbits = 4'd2;
            end
            default:
            begin
                mask  = 8'h0f;
                wbits = 4'd4;
            end
        endcase
        slot_eff = in_data.first ? 3'(4'd8 - {1'b0, in_data.count_low}) : slot_reg;
        acc_base = in_data.first ? 8'h00 : acc_reg;
        pos      = {3'b000, slot_eff} << width_code[1:0];
        shift    = pos[2:0];
        endp     = 3'(pos + {2'b00, wbits});
        acc_new  = acc_base | 8'((in_data.value[7:0] & mask) << shift);

        push_job = '0;
        push_job.last = in_data.last;
        acc_next  = acc_reg;
        slot_next = slot_reg;
        emit      = 1'b0;
        if (sub_byte)
        begin
            emit              = (endp == 3'd0) || in_data.last;
            push_job.data     = {24'h000000, acc_new};
            push_job.nbytes_m1 = 2'd0;
            acc_next  = (emit) ? 8'h00 : acc_new;
            slot_next = in_data.last ? 3'd0 : 3'(slot_eff + 3'd1);
        end
        else
        begin
            emit          = 1'b1;
            push_job.data = in_data.value;
            case (width_code)
                fwip_pkg::WCODE_8:  push_job.nbytes_m1 = 2'd0;
                fwip_pkg::WCODE_16: push_job.nbytes_m1 = 2'd1;
                default:            push_job.nbytes_m1 = 2'd3;
            endcase
            if (in_data.first || in_data.last)
            begin
                acc_next  = 8'h00;
                slot_next = 3'd0;
            end
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 8'h00;
            slot_reg <= 3'd0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            slot_reg <= slot_next;
        end
    end

    // a block always ends on a clean group
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last) |=> (slot_reg == 3'd0 && acc_reg == 8'h00))
        else $error("packer state not cleared after end of block");

endmodule

// ----- rtl/fwip_queue.sv -----
// short job queue between the front and the back
module fwip_queue #(
    parameter int DEPTH = fwip_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fwip_pkg::job_t        push_job,
    input  logic                  pop,
    output fwip_pkg::job_t        head_job,
    output fwip_pkg::queue_stat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fwip_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            count_next = CW'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
        else $error("push into full job queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
        else $error("pop from empty job queue");

endmodule

// ----- rtl/fwip_back.sv -----
// back part: splits queued jobs into bytes behind an output register
module fwip_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fwip_pkg::job_t        head_job,
    input  fwip_pkg::queue_stat_t stat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fwip_pkg::out_item_t   out_data
);

    logic                valid_reg;
    fwip_pkg::out_item_t data_reg, data_next;
    logic [1:0]          idx_reg, idx_next;
    logic                load;
    logic                final_byte;

    assign load       = !stat.empty && (!valid_reg || out_ready);
    assign final_byte = (idx_reg == head_job.nbytes_m1);
    assign pop        = load && final_byte;

    always_comb
    begin
        data_next.out_byte  = 8'(head_job.data >> {idx_reg, 3'b000});
        data_next.last_byte = head_job.last && final_byte;
        idx_next = idx_reg;
        if (load)
            idx_next = final_byte ? 2'd0 : 2'(idx_reg + 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // byte index never passes the job length
    assert property (@(posedge clk) disable iff (!rst_n)
        !stat.empty |-> (idx_reg <= head_job.nbytes_m1))
        else $error("byte index beyond job length");

endmodule

// ----- rtl/fixed_width_integer_packer.sv -----
// top level of the fixed width integer packer
//
// Packs a block of unsigned values into a byte stream at 1, 2, 4, 8, 16 or 32 bits.
// Input channel in_valid/in_ready/in_data carries one value per transfer with its
// first/count_low/last marks; output channel out_valid/out_ready/out_data carries
// one byte per transfer with last_byte set on the final byte of a block.
// cfg_we/cfg_data write the width code; change it only while the block is idle.
// Throughput: one value per cycle at sub-byte widths and at 8 bits while out_ready
// stays high; at 16 and 32 bits the single output byte per cycle limits the rate.
// A byte caused by a value passes from the front into the job queue and then into
// the output register before it appears on out_valid.
// in_ready follows only the job queue, so the front keeps taking values while a
// finished byte waits in the output register; a receiver stall fills the queue
// and then drops in_ready. Nothing is lost or repeated under stalls.
// Reset clears the width code (1 bit), the partial byte, the slot counter, the
// queue and the output register.
module fixed_width_integer_packer #(
    parameter int QUEUE_DEPTH = fwip_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwip_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fwip_pkg::out_item_t out_data
);

    logic [2:0]            width_code_reg;
    logic                  push;
    logic                  pop;
    fwip_pkg::job_t        push_job;
    fwip_pkg::job_t        head_job;
    fwip_pkg::queue_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_code_reg <= fwip_pkg::WCODE_1;
        else if (cfg_we)
            width_code_reg <= cfg_data;
    end

    fwip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_code (width_code_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (stat.full),
        .push       (push),
        .push_job   (push_job)
    );

    fwip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (stat)
    );

    fwip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .stat      (stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the fixed width integer packer
module tb_top;

    localparam logic [2:0] WCODE_SPARE_6 = 3'd6;
    localparam logic [2:0] WCODE_SPARE_7 = 3'd7;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_data;
    logic in_valid;
    logic in_ready;
    fwip_pkg::in_item_t in_data;
    logic out_valid;
    logic out_ready;
    fwip_pkg::out_item_t out_data;

    // packer state as the testbench sees it
    logic [2:0] cur_code;
    logic [7:0] part_byte;
    logic [2:0] slot_idx;
    fwip_pkg::out_item_t expected_bytes[$];

    int send_idle_pct;
    int recv_idle_pct;
    logic long_hold;
    int errors;
    int cycles;

    fixed_width_integer_packer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver side
    always @(posedge clk)
    begin
        out_ready <= !long_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    always @(posedge clk)
    begin : check_bytes
        fwip_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
                flag_error($sformatf("unexpected byte %02h", out_data.out_byte));
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data.out_byte !== want.out_byte)
                    flag_error($sformatf("out_byte %02h, want %02h",
                                         out_data.out_byte, want.out_byte));
                if (out_data.last_byte !== want.last_byte)
                    flag_error($sformatf("last_byte %b, want %b (byte %02h)",
                                         out_data.last_byte, want.last_byte, want.out_byte));
            end
        end
    end

    function automatic int unsigned code_bits(input logic [2:0] code);
        case (code)
            fwip_pkg::WCODE_1:  return 1;
            fwip_pkg::WCODE_2:  return 2;
            fwip_pkg::WCODE_4:  return 4;
            fwip_pkg::WCODE_8:  return 8;
            fwip_pkg::WCODE_16: return 16;
            default:            return 32;
        endcase
    endfunction

    function automatic void predict_bytes(input fwip_pkg::in_item_t item);
        int unsigned w;
        int unsigned shift;
        int unsigned stop;
        logic [31:0] mask;
        fwip_pkg::out_item_t r;
        w = code_bits(cur_code);
        if (w >= 8)
        begin
            for (int k = 0; k < int'(w / 8); k++)
            begin
                r.out_byte  = item.value[8*k +: 8];
                r.last_byte = item.last && (k == int'(w / 8) - 1);
                expected_bytes.push_back(r);
            end
            if (item.first || item.last)
            begin
                part_byte = '0;
                slot_idx  = '0;
            end
        end
        else
        begin
            if (item.first)
            begin
                part_byte = '0;
                slot_idx  = 3'(8 - item.count_low);
            end
            mask  = (32'd1 << w) - 32'd1;
            shift = (int'(slot_idx) * w) % 8;
            stop  = ((int'(slot_idx) + 1) * w) % 8;
            part_byte = part_byte | 8'((item.value & mask) << shift);
            if (stop == 0 || item.last)
            begin
                r.out_byte  = part_byte;
                r.last_byte = item.last;
                expected_bytes.push_back(r);
                part_byte = '0;
            end
            slot_idx = slot_idx + 3'd1;
            if (item.last)
            begin
                slot_idx  = '0;
                part_byte = '0;
            end
        end
    endfunction

    function automatic fwip_pkg::in_item_t mk(input logic [31:0] value, input logic first,
                                              input logic [2:0] count_low, input logic last);
        fwip_pkg::in_item_t item;
        item.value     = value;
        item.first     = first;
        item.count_low = count_low;
        item.last      = last;
        return item;
    endfunction

    task automatic send_value(input fwip_pkg::in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        predict_bytes(item);
    endtask

    task automatic set_width(input logic [2:0] code);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= code;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_code = code;
    endtask

    task automatic send_block(input int len, input bit noisy);
        fwip_pkg::in_item_t item;
        for (int i = 0; i < len; i++)
        begin
            item.value = $urandom;
            if (noisy)
            begin
                item.first     = ($urandom_range(3) == 0);
                item.count_low = 3'($urandom_range(7));
                item.last      = ($urandom_range(3) == 0);
            end
            else
            begin
                item.first     = (i == 0);
                item.count_low = (i == 0) ? 3'(len % 8) : 3'($urandom_range(7));
                item.last      = (i == len - 1);
            end
            send_value(item);
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 20;
        recv_idle_pct = 30;
        set_width(fwip_pkg::WCODE_1);
        send_value(mk(32'hFFFF_FFFF, 1'b1, 3'd3, 1'b0));
        send_value(mk(32'h0000_0000, 1'b0, 3'd0, 1'b0));
        send_value(mk(32'h0000_0001, 1'b0, 3'd0, 1'b1));
        // no first mark after last, then a first mark drops the partial byte
        send_value(mk(32'h0000_0001, 1'b0, 3'd0, 1'b0));
        send_value(mk(32'hFFFF_FFFE, 1'b1, 3'd0, 1'b0));
        send_value(mk(32'hFFFF_FFFF, 1'b0, 3'd0, 1'b1));
        set_width(fwip_pkg::WCODE_2);
        send_value(mk(32'h0000_0003, 1'b1, 3'd1, 1'b0));
        send_value(mk(32'h0000_0002, 1'b0, 3'd0, 1'b1));
        // width change inside a block
        send_value(mk(32'h0000_0001, 1'b1, 3'd6, 1'b0));
        set_width(fwip_pkg::WCODE_4);
        send_value(mk(32'h0000_0005, 1'b0, 3'd0, 1'b1));
        send_value(mk(32'hFFFF_FFFF, 1'b1, 3'd2, 1'b0));
        send_value(mk(32'h0000_000A, 1'b0, 3'd0, 1'b0));
        send_value(mk(32'h0000_0001, 1'b0, 3'd0, 1'b1));
        set_width(fwip_pkg::WCODE_8);
        send_value(mk(32'h1234_56AB, 1'b1, 3'd5, 1'b1));
        send_value(mk(32'h0000_00FF, 1'b0, 3'd0, 1'b0));
        set_width(fwip_pkg::WCODE_16);
        send_value(mk(32'hDEAD_BEEF, 1'b0, 3'd0, 1'b0));
        send_value(mk(32'hFFFF_FFFF, 1'b1, 3'd0, 1'b1));
        set_width(fwip_pkg::WCODE_32);
        send_value(mk(32'h8000_0001, 1'b1, 3'd7, 1'b0));
        send_value(mk(32'hFFFF_FFFF, 1'b0, 3'd0, 1'b1));
        // unused codes act as 32 bits
        set_width(WCODE_SPARE_6);
        send_value(mk(32'h0123_4567, 1'b0, 3'd0, 1'b1));
        set_width(WCODE_SPARE_7);
        send_value(mk(32'h89AB_CDEF, 1'b1, 3'd0, 1'b1));
    endtask

    task automatic test_random(input int n_items, input int sp, input int rp);
        int sent;
        int len;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
                set_width(3'($urandom_range(6, 7)));
            else
                set_width(3'($urandom_range(5)));
            repeat ($urandom_range(1, 4))
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
                send_block(len, $urandom_range(9) == 0);
                sent += len;
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_width(fwip_pkg::WCODE_32);
        fork
            begin
                long_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold <= 1'b0;
            end
        join_none
        send_block(24, 1'b0);
        set_width(fwip_pkg::WCODE_1);
        send_block(30, 1'b0);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        long_hold = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        errors = 0;
        cycles = 0;
        cur_code = fwip_pkg::WCODE_1;
        part_byte = '0;
        slot_idx = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(120, 32, 54);
        test_random(120, 54, 32);
        test_random(120, 0, 0);
        test_backpressure();

        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
